FILE: hw/rtl/ccpc_pkg.sv
`timescale 1ns / 1ps

package ccpc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_W       = 29;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_RX     = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_UPDATE = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_CTRL_PERIOD  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TELEM_PERIOD = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_READY_TMO    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAULT_TMO    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_POWER_ID     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_STATUS_ID    = 3'd5;

    localparam logic [1:0] LINK_NONE  = 2'd0;
    localparam logic [1:0] LINK_READY = 2'd1;
    localparam logic [1:0] LINK_STALE = 2'd2;
    localparam logic [1:0] LINK_FAULT = 2'd3;

    localparam logic [28:0] CTRL_TX_ID  = 29'h068181FE;
    localparam logic [28:0] TELEM_TX_ID = 29'h068182FE;
    localparam logic [28:0] TELEM_RX_ID = 29'h0681827E;

    localparam logic [7:0] FUNC_VOLT   = 8'h00;
    localparam logic [7:0] FUNC_CURR   = 8'h03;
    localparam logic [7:0] FUNC_STATUS = 8'h32;
    localparam logic [7:0] RSP_VOLT    = 8'h84;
    localparam logic [7:0] RSP_CURR    = 8'h82;
    localparam logic [7:0] RSP_TEMP    = 8'h80;

    localparam logic [15:0] TEMP_RESET = 16'd25000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [28:0] rx_id;
        logic [3:0]  rx_len;
        logic [63:0] rx_data;
        logic [31:0] volt_raw;
        logic [31:0] curr_raw;
    } t_in_word;

    typedef struct packed {
        logic        tx_valid;
        logic [28:0] tx_id;
        logic [63:0] tx_data;
        logic        last;
        logic [31:0] volts_word;
        logic        volts_is_float;
        logic [31:0] amps_word;
        logic        amps_is_float;
        logic [15:0] temp_raw;
        logic        term_charging;
        logic [1:0]  link_status;
    } t_out_word;

    typedef struct packed {
        logic [28:0] id;
        logic [63:0] data;
    } t_frame;

    typedef struct packed {
        logic [31:0] volts_word;
        logic        volts_is_float;
        logic [31:0] amps_word;
        logic        amps_is_float;
        logic [15:0] temp_raw;
        logic        term_charging;
        logic [1:0]  link_status;
    } t_snap;

    typedef struct packed {
        logic [1:0]       cnt;
        t_frame [2:0]     frames;
        t_snap            snap;
    } t_job;

    function automatic t_frame ctrl_frame(input logic [7:0] func, input logic [31:0] value,
                                          input logic [7:0] flag);
        t_frame f;
        f.id   = CTRL_TX_ID;
        f.data = {8'h01, func, 8'h00, flag, 32'h0};
        if (func == FUNC_VOLT || func == FUNC_CURR) begin
            f.data[31:0] = value;
        end
        return f;
    endfunction

    function automatic logic [7:0] req_func(input logic [2:0] step);
        logic [7:0] f;
        case (step)
            3'd0:    f = 8'h84;
            3'd1:    f = 8'h82;
            3'd2:    f = 8'h79;
            3'd3:    f = 8'h80;
            3'd4:    f = 8'h83;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

endpackage

FILE: hw/rtl/can_charger_poll_controller_unit.sv
`timescale 1ns / 1ps
// The first result word of an item passes the job queue and then the output register.
// Throughput: one item per cycle while the queue is not full. An item with k frames
// (k = 1..3) yields k words, one if it has none, one per cycle unless i_stall holds them.
// A 4-entry job queue separates the command front end from the output back end.
// Reset: synchronous, active low; restores state register defaults and empties the queue.

module can_charger_poll_controller_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  ccpc_pkg::t_in_word                i_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output ccpc_pkg::t_out_word               o_word,
    input  logic                              i_cfg_we,
    input  logic [ccpc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ccpc_pkg::CFG_W-1:0]        i_cfg_wdata
);
    import ccpc_pkg::*;

    logic push, pop, full, empty;
    t_job push_job, head_job;

    ccpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    ccpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_job)
    );

    ccpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

endmodule

FILE: hw/rtl/ccpc_queue.sv
`timescale 1ns / 1ps

module ccpc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccpc_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ccpc_pkg::t_job o_data
);
    import ccpc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic [QPTR_W:0]   n_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/ccpc_front.sv
`timescale 1ns / 1ps

module ccpc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  ccpc_pkg::t_in_word                i_word,
    input  logic                              i_cfg_we,
    input  logic [ccpc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [ccpc_pkg::CFG_W-1:0]        i_cfg_wdata,
    output logic                              o_push,
    output ccpc_pkg::t_job                    o_job,
    input  logic                              i_full
);
    import ccpc_pkg::*;

    logic [15:0] r_ctrl_period, r_telem_period, r_ready_tmo, r_fault_tmo;
    logic [28:0] r_power_id, r_status_id;

    logic [31:0] r_now, n_now;
    logic [31:0] r_age, n_age;
    logic        r_rx_zero, n_rx_zero;
    logic [31:0] r_ctrl_el, n_ctrl_el;
    logic [31:0] r_req_el, n_req_el;
    logic [1:0]  r_ctrl_step, n_ctrl_step;
    logic [2:0]  r_req_step, n_req_step;
    logic [31:0] r_volt_lim, n_volt_lim;
    logic [31:0] r_curr_lim, n_curr_lim;
    logic        r_on, n_on;
    logic [31:0] r_volts, n_volts;
    logic        r_volts_f, n_volts_f;
    logic [31:0] r_amps, n_amps;
    logic        r_amps_f, n_amps_f;
    logic [15:0] r_temp, n_temp;
    logic        r_chg, n_chg;

    logic        accept;
    logic [31:0] ctrl_el_inc, req_el_inc;
    logic        fire_ctrl, fire_req;
    t_frame      tick_ctrl, tick_req;
    t_job        job;
    logic [1:0]  link;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    assign ctrl_el_inc = r_ctrl_el + 32'd1;
    assign req_el_inc  = r_req_el + 32'd1;
    assign fire_ctrl   = (ctrl_el_inc >= {16'h0, r_ctrl_period});
    assign fire_req    = (req_el_inc >= {16'h0, r_telem_period});

    always_comb begin
        case (r_ctrl_step)
            2'd0:    tick_ctrl = ctrl_frame(FUNC_STATUS, 32'h0, r_on ? 8'h00 : 8'h01);
            2'd1:    tick_ctrl = ctrl_frame(FUNC_VOLT, r_volt_lim, 8'h00);
            default: tick_ctrl = ctrl_frame(FUNC_CURR, r_curr_lim, 8'h00);
        endcase
        tick_req.id   = TELEM_TX_ID;
        tick_req.data = {8'h01, req_func(r_req_step), 48'h0};
    end

    always_comb begin
        n_now       = r_now;
        n_age       = r_age;
        n_rx_zero   = r_rx_zero;
        n_ctrl_el   = r_ctrl_el;
        n_req_el    = r_req_el;
        n_ctrl_step = r_ctrl_step;
        n_req_step  = r_req_step;
        n_volt_lim  = r_volt_lim;
        n_curr_lim  = r_curr_lim;
        n_on        = r_on;
        n_volts     = r_volts;
        n_volts_f   = r_volts_f;
        n_amps      = r_amps;
        n_amps_f    = r_amps_f;
        n_temp      = r_temp;
        n_chg       = r_chg;
        job         = '0;
        case (i_word.cmd)
            CMD_TICK: begin
                n_now     = r_now + 32'd1;
                n_age     = r_age + 32'd1;
                n_ctrl_el = fire_ctrl ? 32'd0 : ctrl_el_inc;
                n_req_el  = fire_req ? 32'd0 : req_el_inc;
                if (fire_ctrl) begin
                    n_ctrl_step = (r_ctrl_step == 2'd2) ? 2'd0 : r_ctrl_step + 2'd1;
                end
                if (fire_req) begin
                    n_req_step = (r_req_step == 3'd4) ? 3'd0 : r_req_step + 3'd1;
                end
                if (fire_ctrl) begin
                    job.frames[0] = tick_ctrl;
                    job.frames[1] = tick_req;
                end else begin
                    job.frames[0] = tick_req;
                end
                job.cnt = {1'b0, fire_ctrl} + {1'b0, fire_req};
            end
            CMD_RX: begin
                if (i_word.rx_len[3]) begin
                    n_age     = 32'd0;
                    n_rx_zero = (r_now == 32'd0);
                    if (i_word.rx_id == TELEM_RX_ID) begin
                        case (i_word.rx_data[55:48])
                            RSP_VOLT: begin
                                n_volts   = i_word.rx_data[31:0];
                                n_volts_f = 1'b0;
                            end
                            RSP_CURR: begin
                                n_amps   = {16'h0, i_word.rx_data[15:0]};
                                n_amps_f = 1'b0;
                            end
                            RSP_TEMP: begin
                                n_temp = i_word.rx_data[15:0];
                            end
                            default: ;
                        endcase
                    end else if (i_word.rx_id == r_power_id) begin
                        n_volts   = i_word.rx_data[63:32];
                        n_volts_f = 1'b1;
                        n_amps    = i_word.rx_data[31:0];
                        n_amps_f  = 1'b1;
                    end else if (i_word.rx_id == r_status_id) begin
                        n_chg = (i_word.rx_data[15:8] == 8'h03) &&
                                (i_word.rx_data[7:0] == 8'h02);
                    end
                end
            end
            CMD_START: begin
                n_volt_lim    = i_word.volt_raw;
                n_curr_lim    = i_word.curr_raw;
                n_on          = 1'b1;
                n_ctrl_el     = 32'd0;
                job.cnt       = 2'd3;
                job.frames[0] = ctrl_frame(FUNC_VOLT, i_word.volt_raw, 8'h00);
                job.frames[1] = ctrl_frame(FUNC_CURR, i_word.curr_raw, 8'h00);
                job.frames[2] = ctrl_frame(FUNC_STATUS, 32'h0, 8'h00);
            end
            CMD_STOP: begin
                n_on          = 1'b0;
                n_curr_lim    = 32'd0;
                n_ctrl_el     = 32'd0;
                job.cnt       = 2'd1;
                job.frames[0] = ctrl_frame(FUNC_STATUS, 32'h0, 8'h01);
            end
            CMD_UPDATE: begin
                if (r_on) begin
                    n_volt_lim = i_word.volt_raw;
                    n_curr_lim = i_word.curr_raw;
                end
            end
            default: ;
        endcase

        if (n_rx_zero) begin
            link = LINK_NONE;
        end else if (n_age > {16'h0, r_fault_tmo}) begin
            link = LINK_FAULT;
        end else if (n_age < {16'h0, r_ready_tmo}) begin
            link = LINK_READY;
        end else begin
            link = LINK_STALE;
        end

        job.snap.volts_word     = n_volts;
        job.snap.volts_is_float = n_volts_f;
        job.snap.amps_word      = n_amps;
        job.snap.amps_is_float  = n_amps_f;
        job.snap.temp_raw       = n_temp;
        job.snap.term_charging  = n_chg;
        job.snap.link_status    = link;
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_period  <= 16'd300;
            r_telem_period <= 16'd200;
            r_ready_tmo    <= 16'd10000;
            r_fault_tmo    <= 16'd15000;
            r_power_id     <= '0;
            r_status_id    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CTRL_PERIOD:  r_ctrl_period  <= i_cfg_wdata[15:0];
                CFG_TELEM_PERIOD: r_telem_period <= i_cfg_wdata[15:0];
                CFG_READY_TMO:    r_ready_tmo    <= i_cfg_wdata[15:0];
                CFG_FAULT_TMO:    r_fault_tmo    <= i_cfg_wdata[15:0];
                CFG_POWER_ID:     r_power_id     <= i_cfg_wdata;
                CFG_STATUS_ID:    r_status_id    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_age       <= '0;
            r_rx_zero   <= 1'b1;
            r_ctrl_el   <= '0;
            r_req_el    <= '0;
            r_ctrl_step <= '0;
            r_req_step  <= '0;
            r_volt_lim  <= '0;
            r_curr_lim  <= '0;
            r_on        <= 1'b0;
            r_volts     <= '0;
            r_volts_f   <= 1'b0;
            r_amps      <= '0;
            r_amps_f    <= 1'b0;
            r_temp      <= TEMP_RESET;
            r_chg       <= 1'b0;
        end else if (accept) begin
            r_now       <= n_now;
            r_age       <= n_age;
            r_rx_zero   <= n_rx_zero;
            r_ctrl_el   <= n_ctrl_el;
            r_req_el    <= n_req_el;
            r_ctrl_step <= n_ctrl_step;
            r_req_step  <= n_req_step;
            r_volt_lim  <= n_volt_lim;
            r_curr_lim  <= n_curr_lim;
            r_on        <= n_on;
            r_volts     <= n_volts;
            r_volts_f   <= n_volts_f;
            r_amps      <= n_amps;
            r_amps_f    <= n_amps_f;
            r_temp      <= n_temp;
            r_chg       <= n_chg;
        end
    end

endmodule

FILE: hw/rtl/ccpc_back.sv
`timescale 1ns / 1ps

module ccpc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  ccpc_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output ccpc_pkg::t_out_word  o_word
);
    import ccpc_pkg::*;

    logic       r_valid;
    t_out_word  r_word, n_word;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       load;
    logic       has;
    logic       is_last;
    logic [1:0] total;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign total   = (i_job.cnt == 2'd0) ? 2'd1 : i_job.cnt;
    assign is_last = (r_idx == total - 2'd1);
    assign has     = (r_idx < i_job.cnt);
    assign o_pop   = load && is_last;
    assign n_idx   = is_last ? 2'd0 : r_idx + 2'd1;

    always_comb begin
        n_word                = '0;
        n_word.tx_valid       = has;
        if (has) begin
            n_word.tx_id   = i_job.frames[r_idx].id;
            n_word.tx_data = i_job.frames[r_idx].data;
        end
        n_word.last           = is_last;
        n_word.volts_word     = i_job.snap.volts_word;
        n_word.volts_is_float = i_job.snap.volts_is_float;
        n_word.amps_word      = i_job.snap.amps_word;
        n_word.amps_is_float  = i_job.snap.amps_is_float;
        n_word.temp_raw       = i_job.snap.temp_raw;
        n_word.term_charging  = i_job.snap.term_charging;
        n_word.link_status    = i_job.snap.link_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= n_idx;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: tb/ccpc_tb_pkg.sv
`timescale 1ns / 1ps

package ccpc_tb_pkg;

    localparam logic [3:0] FULL_LEN = 4'd8;

    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    localparam logic [7:0] FRAME_HDR  = 8'h01;
    localparam logic [7:0] STATUS_ON  = 8'h00;
    localparam logic [7:0] STATUS_OFF = 8'h01;
    localparam logic [7:0] REQ_AUX_A  = 8'h79;
    localparam logic [7:0] REQ_AUX_B  = 8'h83;
    localparam logic [7:0] CHG_BYTE6  = 8'h03;
    localparam logic [7:0] CHG_BYTE7  = 8'h02;

    localparam logic [28:0] ID_ALL_ONES = 29'h1FFFFFFF;

endpackage

FILE: tb/charger_poll_checker.sv
`timescale 1ns / 1ps

module charger_poll_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  ccpc_pkg::t_in_word              i_in_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  ccpc_pkg::t_out_word             i_out_word,
    input  logic                            i_cfg_we,
    input  logic [ccpc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ccpc_pkg::CFG_W-1:0]      i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import ccpc_pkg::*;
    import ccpc_tb_pkg::*;

    typedef enum logic [2:0] {
        PH_STATUS = 3'b001,
        PH_VOLT   = 3'b010,
        PH_CURR   = 3'b100
    } t_ctrl_phase;

    localparam logic [4:0][7:0] POLL_SEQ = {REQ_AUX_B, RSP_TEMP, REQ_AUX_A, RSP_CURR, RSP_VOLT};

    logic [15:0] cfg_ctrl_period, cfg_poll_period, cfg_ready_tmo, cfg_fault_tmo;
    logic [28:0] cfg_power_id, cfg_status_id;

    logic [31:0] ms_count, rx_stamp, ctrl_stamp, poll_stamp;
    t_ctrl_phase ctrl_phase;
    logic [2:0]  poll_phase;
    logic [31:0] volt_lim, curr_lim;
    logic        out_enabled;
    logic [31:0] volts_w, amps_w;
    logic        volts_f, amps_f;
    logic [15:0] temp_w;
    logic        charging;

    t_out_word due_words[$];
    t_out_word want;

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch, %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] due);
        if (got !== due) begin
            report_mismatch($sformatf("%s got %0h, due %0h", name, got, due));
        end
    endtask

    function automatic t_frame ctrl_word(input logic [7:0] func, input logic [31:0] value,
                                         input logic [7:0] flag);
        t_frame f;
        f.id   = CTRL_TX_ID;
        f.data = {FRAME_HDR, func, 8'h00, flag,
                  (func == FUNC_VOLT || func == FUNC_CURR) ? value : 32'h0};
        return f;
    endfunction

    function automatic logic [1:0] link_now();
        logic [31:0] age;
        age = ms_count - rx_stamp;
        if (rx_stamp == 32'h0) return LINK_NONE;
        if (age > {16'h0, cfg_fault_tmo}) return LINK_FAULT;
        if (age < {16'h0, cfg_ready_tmo}) return LINK_READY;
        return LINK_STALE;
    endfunction

    task automatic restore_defaults();
        cfg_ctrl_period = 16'd300;
        cfg_poll_period = 16'd200;
        cfg_ready_tmo   = 16'd10000;
        cfg_fault_tmo   = 16'd15000;
        cfg_power_id    = '0;
        cfg_status_id   = '0;
        ms_count    = '0;
        rx_stamp    = '0;
        ctrl_stamp  = '0;
        poll_stamp  = '0;
        ctrl_phase  = PH_STATUS;
        poll_phase  = '0;
        volt_lim    = '0;
        curr_lim    = '0;
        out_enabled = 1'b0;
        volts_w     = '0;
        amps_w      = '0;
        volts_f     = 1'b0;
        amps_f      = 1'b0;
        temp_w      = TEMP_RESET;
        charging    = 1'b0;
        o_fail_count = 0;
        due_words.delete();
    endtask

    task automatic predict_command(input t_in_word w);
        t_frame    sent[$];
        t_out_word r;
        t_frame    f;
        int        n;
        case (w.cmd)
            CMD_TICK: begin
                ms_count = ms_count + 32'd1;
                if ((ms_count - ctrl_stamp) >= {16'h0, cfg_ctrl_period}) begin
                    ctrl_stamp = ms_count;
                    case (ctrl_phase)
                        PH_STATUS: begin
                            sent.push_back(ctrl_word(FUNC_STATUS, 32'h0,
                                                     out_enabled ? STATUS_ON : STATUS_OFF));
                            ctrl_phase = PH_VOLT;
                        end
                        PH_VOLT: begin
                            sent.push_back(ctrl_word(FUNC_VOLT, volt_lim, 8'h00));
                            ctrl_phase = PH_CURR;
                        end
                        default: begin
                            sent.push_back(ctrl_word(FUNC_CURR, curr_lim, 8'h00));
                            ctrl_phase = PH_STATUS;
                        end
                    endcase
                end
                if ((ms_count - poll_stamp) >= {16'h0, cfg_poll_period}) begin
                    poll_stamp = ms_count;
                    f.id   = TELEM_TX_ID;
                    f.data = {FRAME_HDR, POLL_SEQ[poll_phase], 48'h0};
                    sent.push_back(f);
                    poll_phase = (poll_phase == 3'd4) ? 3'd0 : poll_phase + 3'd1;
                end
            end
            CMD_RX: begin
                if (w.rx_len >= FULL_LEN) begin
                    rx_stamp = ms_count;
                    if (w.rx_id == TELEM_RX_ID) begin
                        case (w.rx_data[55:48])
                            RSP_VOLT: begin
                                volts_w = w.rx_data[31:0];
                                volts_f = 1'b0;
                            end
                            RSP_CURR: begin
                                amps_w = {16'h0, w.rx_data[15:0]};
                                amps_f = 1'b0;
                            end
                            RSP_TEMP: temp_w = w.rx_data[15:0];
                            default: ;
                        endcase
                    end else if (w.rx_id == cfg_power_id) begin
                        volts_w = w.rx_data[63:32];
                        volts_f = 1'b1;
                        amps_w  = w.rx_data[31:0];
                        amps_f  = 1'b1;
                    end else if (w.rx_id == cfg_status_id) begin
                        charging = (w.rx_data[15:8] == CHG_BYTE6) &&
                                   (w.rx_data[7:0] == CHG_BYTE7);
                    end
                end
            end
            CMD_START: begin
                volt_lim    = w.volt_raw;
                curr_lim    = w.curr_raw;
                out_enabled = 1'b1;
                sent.push_back(ctrl_word(FUNC_VOLT, w.volt_raw, 8'h00));
                sent.push_back(ctrl_word(FUNC_CURR, w.curr_raw, 8'h00));
                sent.push_back(ctrl_word(FUNC_STATUS, 32'h0, STATUS_ON));
                ctrl_stamp = ms_count;
            end
            CMD_STOP: begin
                out_enabled = 1'b0;
                curr_lim    = '0;
                sent.push_back(ctrl_word(FUNC_STATUS, 32'h0, STATUS_OFF));
                ctrl_stamp = ms_count;
            end
            CMD_UPDATE: begin
                if (out_enabled) begin
                    volt_lim = w.volt_raw;
                    curr_lim = w.curr_raw;
                end
            end
            default: ;
        endcase

        n = (sent.size() == 0) ? 1 : sent.size();
        for (int k = 0; k < n; k++) begin
            r = '0;
            if (k < sent.size()) begin
                r.tx_valid = 1'b1;
                r.tx_id    = sent[k].id;
                r.tx_data  = sent[k].data;
            end
            r.last           = (k == n - 1);
            r.volts_word     = volts_w;
            r.volts_is_float = volts_f;
            r.amps_word      = amps_w;
            r.amps_is_float  = amps_f;
            r.temp_raw       = temp_w;
            r.term_charging  = charging;
            r.link_status    = link_now();
            due_words.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CTRL_PERIOD:  cfg_ctrl_period = i_cfg_wdata[15:0];
                    CFG_TELEM_PERIOD: cfg_poll_period = i_cfg_wdata[15:0];
                    CFG_READY_TMO:    cfg_ready_tmo   = i_cfg_wdata[15:0];
                    CFG_FAULT_TMO:    cfg_fault_tmo   = i_cfg_wdata[15:0];
                    CFG_POWER_ID:     cfg_power_id    = i_cfg_wdata[28:0];
                    CFG_STATUS_ID:    cfg_status_id   = i_cfg_wdata[28:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_command(i_in_word);
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    report_mismatch("result word with none due");
                end else begin
                    want = due_words.pop_front();
                    check_field("tx_valid", i_out_word.tx_valid, want.tx_valid);
                    check_field("tx_id", i_out_word.tx_id, want.tx_id);
                    check_field("tx_data", i_out_word.tx_data, want.tx_data);
                    check_field("last", i_out_word.last, want.last);
                    check_field("volts_word", i_out_word.volts_word, want.volts_word);
                    check_field("volts_is_float", i_out_word.volts_is_float,
                                want.volts_is_float);
                    check_field("amps_word", i_out_word.amps_word, want.amps_word);
                    check_field("amps_is_float", i_out_word.amps_is_float,
                                want.amps_is_float);
                    check_field("temp_raw", i_out_word.temp_raw, want.temp_raw);
                    check_field("term_charging", i_out_word.term_charging,
                                want.term_charging);
                    check_field("link_status", i_out_word.link_status, want.link_status);
                end
            end
        end
        o_pending = due_words.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ccpc_pkg::*;
    import ccpc_tb_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_word              i_word;
    logic                  o_valid;
    logic                  i_stall;
    t_out_word             o_word;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    int          fail_count;
    int          pending;
    bit          idling;
    logic [28:0] power_id, status_id, spare_id;

    can_charger_poll_controller_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    charger_poll_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_word    (i_word),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_word   (o_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        i_stall <= idling && ($urandom_range(0, 99) < 36);
    end

    function automatic t_in_word rand_word();
        t_in_word w;
        w.cmd      = 3'($urandom);
        w.rx_id    = 29'($urandom);
        w.rx_len   = 4'($urandom);
        w.rx_data  = {$urandom, $urandom};
        w.volt_raw = $urandom;
        w.curr_raw = $urandom;
        return w;
    endfunction

    function automatic t_in_word cmd_word(input logic [2:0] cmd, input logic [31:0] volt,
                                          input logic [31:0] curr);
        t_in_word w;
        w          = rand_word();
        w.cmd      = cmd;
        w.volt_raw = volt;
        w.curr_raw = curr;
        return w;
    endfunction

    function automatic t_in_word rx_word(input logic [28:0] id, input logic [3:0] len,
                                         input logic [7:0] func);
        t_in_word w;
        w                = rand_word();
        w.cmd            = CMD_RX;
        w.rx_id          = id;
        w.rx_len         = len;
        w.rx_data[55:48] = func;
        return w;
    endfunction

    function automatic t_in_word random_item();
        t_in_word w;
        int       pick;
        w    = rand_word();
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            w.cmd = CMD_TICK;
        end else if (pick < 72) begin
            w.cmd = CMD_RX;
            case ($urandom_range(0, 3))
                0: begin
                    w.rx_id = TELEM_RX_ID;
                    case ($urandom_range(0, 4))
                        0: w.rx_data[55:48] = RSP_VOLT;
                        1: w.rx_data[55:48] = RSP_CURR;
                        2: w.rx_data[55:48] = RSP_TEMP;
                        3: w.rx_data[55:48] = REQ_AUX_A;
                        default: ;
                    endcase
                end
                1: w.rx_id = power_id;
                2: begin
                    w.rx_id = status_id;
                    if ($urandom_range(0, 1) == 0) w.rx_data[15:0] = {CHG_BYTE6, CHG_BYTE7};
                end
                default: ;
            endcase
            if ($urandom_range(0, 4) != 0) w.rx_len = FULL_LEN;
        end else if (pick < 80) begin
            w.cmd = CMD_START;
        end else if (pick < 87) begin
            w.cmd = CMD_STOP;
        end else if (pick < 96) begin
            w.cmd = CMD_UPDATE;
        end else begin
            w.cmd = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        while (idling && $urandom_range(0, 99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] ctrl_p, input logic [15:0] poll_p,
                                  input logic [15:0] ready_t, input logic [15:0] fault_t,
                                  input logic [28:0] pid, input logic [28:0] sid);
        power_id  = pid;
        status_id = sid;
        cfg_put(CFG_CTRL_PERIOD, {13'h0, ctrl_p});
        cfg_put(CFG_TELEM_PERIOD, {13'h0, poll_p});
        cfg_put(CFG_READY_TMO, {13'h0, ready_t});
        cfg_put(CFG_FAULT_TMO, {13'h0, fault_t});
        cfg_put(CFG_POWER_ID, pid);
        cfg_put(CFG_STATUS_ID, sid);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(random_item());
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_word      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        idling    = 1'b1;
        power_id  = '0;
        status_id = '0;
        spare_id  = 29'($urandom) | 29'h1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: frame before the first tick, unused commands, update while off
        send_word(rx_word(29'h0, FULL_LEN, 8'($urandom)));
        send_word(cmd_word(CMD_FIRST_UNUSED, $urandom, $urandom));
        send_word(cmd_word(CMD_LAST_UNUSED, $urandom, $urandom));
        send_word(cmd_word(CMD_UPDATE, $urandom, $urandom));
        drain();

        // shortest periods, short timeouts; status id aliases the telemetry response id
        apply_settings(16'd1, 16'd1, 16'd2, 16'd4, ID_ALL_ONES, TELEM_RX_ID);
        send_word(cmd_word(CMD_TICK, $urandom, $urandom));
        send_word(cmd_word(CMD_START, 32'hFFFFFFFF, 32'h0));
        send_word(cmd_word(CMD_TICK, $urandom, $urandom));
        send_word(cmd_word(CMD_UPDATE, 32'h0, 32'hFFFFFFFF));
        send_word(rx_word(TELEM_RX_ID, FULL_LEN, RSP_VOLT));
        send_word(rx_word(TELEM_RX_ID, 4'hF, RSP_CURR));
        send_word(rx_word(TELEM_RX_ID, FULL_LEN, RSP_TEMP));
        send_word(rx_word(TELEM_RX_ID, FULL_LEN, REQ_AUX_A));
        send_word(rx_word(ID_ALL_ONES, FULL_LEN - 4'd1, 8'($urandom)));
        send_word(rx_word(ID_ALL_ONES, FULL_LEN, 8'($urandom)));
        repeat (5) send_word(cmd_word(CMD_TICK, $urandom, $urandom));
        send_word(cmd_word(CMD_STOP, $urandom, $urandom));
        send_word(cmd_word(CMD_TICK, $urandom, $urandom));
        drain();

        // longest periods and timeouts; terminal status decode
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 29'h0, spare_id);
        send_word(cmd_word(CMD_RX, $urandom, $urandom));
        i_word.rx_id <= spare_id;
        i_word.rx_len <= FULL_LEN;
        i_word.rx_data[15:0] <= {CHG_BYTE6, CHG_BYTE7};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        send_word(rx_word(spare_id, FULL_LEN, 8'($urandom)));
        send_word(cmd_word(CMD_TICK, $urandom, $urandom));
        drain();

        apply_settings(16'd3, 16'd2, 16'd5, 16'd9, 29'($urandom), 29'($urandom));
        run_random(65);
        drain();

        apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 29'($urandom), TELEM_RX_ID);
        run_random(65);
        drain();

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 29'($urandom), 29'($urandom));
        run_random(40);
        drain();

        // no idling on either side; power and status share one id
        spare_id = 29'($urandom);
        idling   = 1'b0;
        apply_settings(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                       16'($urandom_range(1, 12)), 16'($urandom_range(1, 20)),
                       spare_id, spare_id);
        run_random(90);
        drain();

        idling = 1'b1;
        apply_settings(16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                       16'($urandom_range(1, 10)), 16'($urandom_range(1, 16)),
                       29'($urandom), 29'($urandom));
        run_random(70);
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ccpc_pkg.sv
hw/rtl/ccpc_queue.sv
hw/rtl/ccpc_front.sv
hw/rtl/ccpc_back.sv
hw/rtl/can_charger_poll_controller_unit.sv
tb/ccpc_tb_pkg.sv
tb/charger_poll_checker.sv
tb/tb_top.sv
